// ----- rtl/multi_width_checksum_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Checksum engine assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_WIDTH_CHECKSUM_ENGINE_MACROS_SVH
`define MULTI_WIDTH_CHECKSUM_ENGINE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MWCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MWCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mwce_pkg.sv -----
// ----------------------------------------------------------------------------
// mwce_pkg
// Mode codes, widths and shared types of the checksum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mwce_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 32;
    localparam int MODE_W = 3;
    localparam int LANE_W = 2;

    typedef logic [MODE_W-1:0] mwce_mode_t;

    localparam mwce_mode_t MODE_XOR8   = 3'd0;
    localparam mwce_mode_t MODE_ADD8   = 3'd1;
    localparam mwce_mode_t MODE_XOR16  = 3'd2;
    localparam mwce_mode_t MODE_ADD16  = 3'd3;
    localparam mwce_mode_t MODE_ONES16 = 3'd4;
    localparam mwce_mode_t MODE_XOR32  = 3'd5;
    localparam mwce_mode_t MODE_ADD32  = 3'd6;

    localparam logic [15:0] ONES_MAX  = 16'hffff;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } mwce_item_t;

    typedef struct packed {
        logic              take;
        logic [LANE_W-1:0] lane;
    } mwce_status_t;

endpackage

`default_nettype wire

// ----- rtl/mwce_intf.sv -----
// ----------------------------------------------------------------------------
// mwce_intf
// Valid/ready channels of the checksum engine: config, message bytes, result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwce_cfg_if;
    import mwce_pkg::*;
    logic       valid;
    logic       ready;
    mwce_mode_t checksum_mode;
    modport source (output valid, output checksum_mode, input ready);
    modport sink (input valid, input checksum_mode, output ready);
endinterface

interface mwce_byte_if;
    import mwce_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mwce_sum_if;
    import mwce_pkg::*;
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] checksum;
    modport source (output valid, output checksum, input ready);
    modport sink (input valid, input checksum, output ready);
endinterface

`default_nettype wire

// ----- rtl/mwce_in_stage.sv -----
// ----------------------------------------------------------------------------
// mwce_in_stage
// Input register: holds one byte transfer until the fold stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mwce_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [mwce_pkg::BYTE_W-1:0] in_data,
    input  logic                      in_last,
    output logic                      in_ready,
    input  logic                      take,
    output mwce_pkg::mwce_item_t      item
);
    import mwce_pkg::*;

    mwce_item_t item_reg;
    mwce_item_t item_next;

    assign in_ready = !item_reg.valid || take;
    assign item     = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (in_valid && in_ready)
        begin
            item_next.valid = 1'b1;
            item_next.data  = in_data;
            item_next.last  = in_last;
        end
        else if (take)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mwce_fold.sv -----
// ----------------------------------------------------------------------------
// mwce_fold
// Folds one byte into the accumulator and registers the checksum on the last.
// ----------------------------------------------------------------------------
`default_nettype none

module mwce_fold (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwce_pkg::mwce_item_t       item,
    input  mwce_pkg::mwce_mode_t       mode,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [mwce_pkg::SUM_W-1:0] out_checksum,
    output mwce_pkg::mwce_status_t     status
);
    import mwce_pkg::*;

    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  checksum_reg;
    logic [SUM_W-1:0]  checksum_next;

    logic              out_free;
    logic              take;
    logic [SUM_W-1:0]  fold;
    logic [SUM_W-1:0]  result;
    logic [15:0]       b16;
    logic [SUM_W-1:0]  b32;
    logic [16:0]       ones_sum;
    logic [15:0]       ones_fold;

    assign out_free = !out_valid_reg || out_ready;
    assign take     = item.valid && (!item.last || out_free);

    assign status.take = take;
    assign status.lane = lane_reg;

    assign out_valid    = out_valid_reg;
    assign out_checksum = checksum_reg;

    // Big-endian lane placement
    assign b16 = lane_reg[0] ? {8'h00, item.data} : {item.data, 8'h00};

    always_comb
    begin
        case (lane_reg)
            2'd0:    b32 = {item.data, 24'h000000};
            2'd1:    b32 = {8'h00, item.data, 16'h0000};
            2'd2:    b32 = {16'h0000, item.data, 8'h00};
            default: b32 = {24'h000000, item.data};
        endcase
    end

    // End-around carry
    assign ones_sum  = {1'b0, acc_reg[15:0]} + {1'b0, b16};
    assign ones_fold = ones_sum[16] ? ones_sum[15:0] + 16'd1 : ones_sum[15:0];

    always_comb
    begin
        case (mode)
            MODE_XOR8:   fold = acc_reg ^ {24'h000000, item.data};
            MODE_ADD8:   fold = {24'h000000, acc_reg[7:0] + item.data};
            MODE_XOR16:  fold = acc_reg ^ {16'h0000, b16};
            MODE_ADD16:  fold = {16'h0000, acc_reg[15:0] + b16};
            MODE_ONES16: fold = {16'h0000, ones_fold};
            MODE_XOR32:  fold = acc_reg ^ b32;
            MODE_ADD32:  fold = acc_reg + b32;
            default:     fold = acc_reg;
        endcase
    end

    always_comb
    begin
        case (mode)
            MODE_XOR8, MODE_ADD8:   result = {24'h000000, fold[7:0]};
            MODE_XOR16, MODE_ADD16: result = {16'h0000, fold[15:0]};
            MODE_ONES16:
            begin
                if (fold[15:0] == ONES_MAX)
                    result = '0;
                else
                    result = {16'h0000, fold[15:0]};
            end
            MODE_XOR32, MODE_ADD32: result = fold;
            default:                result = '0;
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg;
        checksum_next  = checksum_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (take)
        begin
            if (item.last)
            begin
                acc_next       = '0;
                lane_next      = '0;
                out_valid_next = 1'b1;
                checksum_next  = result;
            end
            else
            begin
                acc_next  = fold;
                lane_next = lane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        checksum_reg <= checksum_next;
    end

endmodule

`default_nettype wire

// ----- rtl/multi_width_checksum_engine.sv -----
// ----------------------------------------------------------------------------
// multi_width_checksum_engine
// Byte-serial XOR, sum and ones' complement checksums over 8/16/32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - one-register write channel, checksum_mode, always ready. Write it
//            between messages.
//   msg    - one message byte per transfer, last_byte on the final byte.
//   result - one checksum transfer per message, zero-extended to 32 bits.
// Timing:
//   One byte per cycle sustained while result is not stalled. A byte is held
//   in the input register and folded into the accumulator when the fold stage
//   takes it; for a last byte the checksum is then registered onto result.
// Stall:
//   The result register holds while result.ready is low. Non-last bytes keep
//   flowing; a last byte waits in the input register until the result
//   register is free, and msg.ready drops behind it.
// Reset:
//   Mode returns to xor8, accumulator and lane position clear, no result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_width_checksum_engine_macros.svh"

module multi_width_checksum_engine (
    input  logic              clk,
    input  logic              rst_n,
    mwce_cfg_if.sink          cfg,
    mwce_byte_if.sink         msg,
    mwce_sum_if.source        result
);
    import mwce_pkg::*;

    mwce_mode_t   mode_reg;
    mwce_mode_t   mode_next;
    mwce_item_t   item;
    mwce_status_t status;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg.valid && cfg.ready)
            mode_next = cfg.checksum_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_XOR8;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    mwce_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_data  (msg.data_byte),
        .in_last  (msg.last_byte),
        .in_ready (msg.ready),
        .take     (status.take),
        .item     (item)
    );

    mwce_fold u_fold (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .mode         (mode_reg),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_checksum (result.checksum),
        .status       (status)
    );

    `MWCE_ASSERT_SAME(a_stall_only_on_last, !msg.ready, item.valid && item.last, "msg stalled without a last byte waiting")
    `MWCE_ASSERT_NEXT(a_lane_clear, status.take && item.last, status.lane == 2'd0, "lane not cleared after last byte")
    `MWCE_ASSERT_SAME(a_result_from_last, $rose(result.valid), $past(status.take && item.last), "result without a last byte")

endmodule

`default_nettype wire
